// ----- src/tod_pkg.sv -----
// constants, command codes and wrap helpers for the time-of-day clock
// no dependencies; used by time_of_day_clock
package tod_pkg;

  localparam int TPS_W = 16;
  localparam int HOUR_W = 5;
  localparam int MIN_W = 6;
  localparam int SEC_W = 6;
  localparam int BTN_W = 6;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 24;

  localparam logic [TPS_W-1:0] TPS_RESET = 16'd300;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;
  localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
  localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BUTTONS = 1'b1;

  localparam int BTN_HOUR_UP = 0;
  localparam int BTN_MIN_UP = 1;
  localparam int BTN_SEC_UP = 2;
  localparam int BTN_HOUR_DOWN = 3;
  localparam int BTN_MIN_DOWN = 4;
  localparam int BTN_SEC_DOWN = 5;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
  } tod_time_t;

  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] modulus);
    logic [6:0] s;
    s = {1'b0, v} + 7'd1;
    return (s >= {1'b0, modulus}) ? 6'd0 : s[5:0];
  endfunction

  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] modulus);
    logic [5:0] top;
    top = modulus - 6'd1;
    return (v == 6'd0 || v > top) ? top : v - 6'd1;
  endfunction

endpackage

// ----- src/time_of_day_clock.sv -----
// 24-hour time-of-day clock with prescaled tick input and six set buttons
// depends on tod_pkg
// a beat waits in the input register, and its result then waits in the result register
// one beat per cycle unless the output stalls; each state update is one short pass of logic
// rst (synchronous) clears the time, prescaler, button history and both stages,
// and sets ticks_per_second to 300
module time_of_day_clock (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [tod_pkg::TPS_W-1:0]          cfg_wr_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tod_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // buttons[5:0], zero pad
  input  logic                               s_axis_tuser,  // command
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tod_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // hours, minutes, seconds, pad
  output logic                               m_axis_tuser   // display_update
);

  logic [tod_pkg::TPS_W-1:0] ticks_per_second;
  logic [tod_pkg::TPS_W-1:0] prescaler, prescaler_next;
  logic [tod_pkg::BTN_W-1:0] previous_buttons, previous_buttons_next;
  tod_pkg::tod_time_t        now, now_next;
  logic                      update_next;

  logic                      in_valid;
  logic                      in_command;
  logic [tod_pkg::BTN_W-1:0] in_buttons;

  logic                      adv_out;
  logic                      adv_in;

  tod_pkg::tod_time_t        out_time;
  logic                      out_update;

  assign adv_out = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv_out;
  assign adv_in = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= tod_pkg::TPS_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= adv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) begin
      in_command <= s_axis_tuser;
      in_buttons <= s_axis_tdata[tod_pkg::BTN_W-1:0];
    end
  end

  // state update for the beat in the input register
  always_comb begin
    logic [tod_pkg::TPS_W-1:0] pre_inc;
    logic [tod_pkg::BTN_W-1:0] fell;
    logic [5:0]                h, m, s;
    pre_inc = prescaler + 16'd1;
    fell = previous_buttons & ~in_buttons;
    h = {1'b0, now.hours};
    m = now.minutes;
    s = now.seconds;
    prescaler_next = prescaler;
    previous_buttons_next = previous_buttons;
    update_next = 1'b0;
    if (in_command == tod_pkg::CMD_TICK) begin
      if (pre_inc >= ticks_per_second) begin
        prescaler_next = '0;
        update_next = 1'b1;
        s = tod_pkg::wrap_up(s, tod_pkg::SECONDS_PER_MINUTE);
        if (s == 6'd0) begin
          m = tod_pkg::wrap_up(m, tod_pkg::MINUTES_PER_HOUR);
          if (m == 6'd0) begin
            h = tod_pkg::wrap_up(h, tod_pkg::HOURS_PER_DAY);
          end
        end
      end else begin
        prescaler_next = pre_inc;
      end
    end else begin
      if (fell[tod_pkg::BTN_HOUR_UP]) h = tod_pkg::wrap_up(h, tod_pkg::HOURS_PER_DAY);
      if (fell[tod_pkg::BTN_MIN_UP]) m = tod_pkg::wrap_up(m, tod_pkg::MINUTES_PER_HOUR);
      if (fell[tod_pkg::BTN_SEC_UP]) s = tod_pkg::wrap_up(s, tod_pkg::SECONDS_PER_MINUTE);
      if (fell[tod_pkg::BTN_HOUR_DOWN]) h = tod_pkg::wrap_down(h, tod_pkg::HOURS_PER_DAY);
      if (fell[tod_pkg::BTN_MIN_DOWN]) m = tod_pkg::wrap_down(m, tod_pkg::MINUTES_PER_HOUR);
      if (fell[tod_pkg::BTN_SEC_DOWN]) s = tod_pkg::wrap_down(s, tod_pkg::SECONDS_PER_MINUTE);
      update_next = (fell != '0);
      previous_buttons_next = in_buttons;
    end
    now_next.hours = h[tod_pkg::HOUR_W-1:0];
    now_next.minutes = m;
    now_next.seconds = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler <= '0;
      previous_buttons <= '0;
      now <= '0;
    end else if (adv_out) begin
      prescaler <= prescaler_next;
      previous_buttons <= previous_buttons_next;
      now <= now_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_time <= now_next;
      out_update <= update_next;
    end
  end

  assign m_axis_tdata = {7'd0, out_time.seconds, out_time.minutes, out_time.hours};
  assign m_axis_tuser = out_update;

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    now.hours < 5'd24 && now.minutes < 6'd60 && now.seconds < 6'd60)
    else $error("time out of range");

  a_prescaler_below_max: assert property (@(posedge clk) disable iff (rst)
    prescaler != 16'hFFFF)
    else $error("prescaler reached its maximum");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    adv_out |=> (out_time == now))
    else $error("result does not match updated time");

  a_tick_keeps_buttons: assert property (@(posedge clk) disable iff (rst)
    adv_out && in_command == tod_pkg::CMD_TICK |=> $stable(previous_buttons))
    else $error("tick changed button history");

endmodule

// ----- tb/sv/time_of_day_check.sv -----
`timescale 1ns / 100ps
// watches the configuration port and both streams of time_of_day_clock, predicts every
// result from its own copy of the clock state and compares field by field; uses tod_pkg
module time_of_day_check (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_wr_en,
  input  logic [tod_pkg::TPS_W-1:0]                 cfg_wr_data,
  input  logic                                      s_axis_tvalid,
  input  logic                                      s_axis_tready,
  input  logic [tod_pkg::IN_TDATA_W-1:0]            s_axis_tdata,
  input  logic                                      s_axis_tuser,
  input  logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  input  logic [tod_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  input  logic                                      m_axis_tuser,
  output int                                        mismatches,
  output int                                        pending,
  output int                                        readings,
  output int                                        updates
);

  typedef struct {
    logic [tod_pkg::HOUR_W-1:0] hours;
    logic [tod_pkg::MIN_W-1:0]  minutes;
    logic [tod_pkg::SEC_W-1:0]  seconds;
    logic                       display_update;
  } reading_t;

  reading_t                  expected_readings[$];
  logic [tod_pkg::TPS_W-1:0] rate;
  logic [tod_pkg::TPS_W-1:0] prescale;
  logic [5:0]                hours;
  logic [5:0]                minutes;
  logic [5:0]                seconds;
  logic [tod_pkg::BTN_W-1:0] last_buttons;
  int                        fail_count = 0;
  int                        checked = 0;
  int                        update_count = 0;

  function automatic logic [5:0] count_up(input logic [5:0] v, input logic [5:0] modulus);
    return (v + 6'd1 >= modulus) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] count_down(input logic [5:0] v, input logic [5:0] modulus);
    return (v == 6'd0 || v > modulus - 6'd1) ? modulus - 6'd1 : v - 6'd1;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reading_t                  want;
    reading_t                  next_reading;
    logic [tod_pkg::BTN_W-1:0] buttons;
    logic [tod_pkg::BTN_W-1:0] fell;
    logic [tod_pkg::TPS_W-1:0] bumped;
    if (rst) begin
      rate = tod_pkg::TPS_RESET;
      prescale = '0;
      hours = '0;
      minutes = '0;
      seconds = '0;
      last_buttons = '0;
      expected_readings.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t unexpected result beat: expected none, actual %h / %b", $time,
                   m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          checked++;
          if (m_axis_tdata[4:0] !== want.hours)
            report("hours", 32'(want.hours), 32'(m_axis_tdata[4:0]));
          if (m_axis_tdata[10:5] !== want.minutes)
            report("minutes", 32'(want.minutes), 32'(m_axis_tdata[10:5]));
          if (m_axis_tdata[16:11] !== want.seconds)
            report("seconds", 32'(want.seconds), 32'(m_axis_tdata[16:11]));
          if (m_axis_tdata[23:17] !== '0) report("padding", 32'd0, 32'(m_axis_tdata[23:17]));
          if (m_axis_tuser !== want.display_update)
            report("display_update", 32'(want.display_update), 32'(m_axis_tuser));
        end
      end
      if (cfg_wr_en) rate = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        buttons = s_axis_tdata[tod_pkg::BTN_W-1:0];
        next_reading.display_update = 1'b0;
        if (s_axis_tuser == tod_pkg::CMD_TICK) begin
          bumped = prescale + 1'b1;
          if (bumped >= rate) begin
            prescale = '0;
            next_reading.display_update = 1'b1;
            seconds = count_up(seconds, tod_pkg::SECONDS_PER_MINUTE);
            if (seconds == 6'd0) begin
              minutes = count_up(minutes, tod_pkg::MINUTES_PER_HOUR);
              if (minutes == 6'd0) hours = count_up(hours, tod_pkg::HOURS_PER_DAY);
            end
          end else begin
            prescale = bumped;
          end
        end else begin
          // released buttons only, applied in fixed order
          fell = last_buttons & ~buttons;
          if (fell[tod_pkg::BTN_HOUR_UP]) hours = count_up(hours, tod_pkg::HOURS_PER_DAY);
          if (fell[tod_pkg::BTN_MIN_UP])
            minutes = count_up(minutes, tod_pkg::MINUTES_PER_HOUR);
          if (fell[tod_pkg::BTN_SEC_UP])
            seconds = count_up(seconds, tod_pkg::SECONDS_PER_MINUTE);
          if (fell[tod_pkg::BTN_HOUR_DOWN])
            hours = count_down(hours, tod_pkg::HOURS_PER_DAY);
          if (fell[tod_pkg::BTN_MIN_DOWN])
            minutes = count_down(minutes, tod_pkg::MINUTES_PER_HOUR);
          if (fell[tod_pkg::BTN_SEC_DOWN])
            seconds = count_down(seconds, tod_pkg::SECONDS_PER_MINUTE);
          next_reading.display_update = |fell;
          last_buttons = buttons;
        end
        next_reading.hours = hours[tod_pkg::HOUR_W-1:0];
        next_reading.minutes = minutes;
        next_reading.seconds = seconds;
        if (next_reading.display_update) update_count++;
        expected_readings.push_back(next_reading);
      end
    end
    mismatches <= fail_count;
    pending <= expected_readings.size();
    readings <= checked;
    updates <= update_count;
  end

endmodule

// ----- tb/sv/time_of_day_clock_test.sv -----
`timescale 1ns / 100ps
// top of the time_of_day_clock testbench: clock, reset, rate settings, tick and button beats
// with random gaps and stalls; depends on tod_pkg, time_of_day_clock and time_of_day_check
module time_of_day_clock_test;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BEATS = 200;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [tod_pkg::TPS_W-1:0]        cfg_wr_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [tod_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;   // buttons[5:0], zero pad
  logic                             s_axis_tuser = 1'b0; // command
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [tod_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;        // hours, minutes, seconds, pad
  logic                             m_axis_tuser;        // display_update

  int   mismatches;
  int   pending;
  int   readings;
  int   updates;
  int   beats = 0;
  int   rate_writes = 0;
  int   stalled = 0;
  logic steady = 1'b0;

  time_of_day_clock DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  time_of_day_check checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .pending       (pending),
    .readings      (readings),
    .updates       (updates)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled <= 0;
    end else if (stalled >= STALL_LIMIT) begin
      $display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  task automatic send_beat(input logic cmd, input logic [tod_pkg::BTN_W-1:0] buttons);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, buttons};
    do @(posedge clk); while (!s_axis_tready);
    beats++;
  endtask

  // drain all results, then allow for the two-stage pipeline
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rate(input logic [tod_pkg::TPS_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rate_writes++;
  endtask

  initial begin
    logic [tod_pkg::TPS_W-1:0] rate_plan[8];
    logic [tod_pkg::BTN_W-1:0] press;
    int                        sent;
    int                        pick;
    rate_plan = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd5, 16'd3, 16'd0, 16'd300};
    rate_plan[6] = 16'($urandom_range(1, 12));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset rate: first sample fires nothing, then all six released together
    send_beat(tod_pkg::CMD_BUTTONS, 6'h3F);
    send_beat(tod_pkg::CMD_BUTTONS, 6'h00);
    // downs from midnight wrap to 23:59:59
    send_beat(tod_pkg::CMD_BUTTONS, 6'h38);
    send_beat(tod_pkg::CMD_BUTTONS, 6'h00);
    // buttons on a tick are ignored
    send_beat(tod_pkg::CMD_TICK, 6'h3F);
    // ups wrap each field back to zero
    send_beat(tod_pkg::CMD_BUTTONS, 6'h07);
    send_beat(tod_pkg::CMD_BUTTONS, 6'h00);

    // full cascade from 23:59:59
    set_rate(16'd1);
    send_beat(tod_pkg::CMD_BUTTONS, 6'h38);
    send_beat(tod_pkg::CMD_BUTTONS, 6'h00);
    send_beat(tod_pkg::CMD_TICK, 6'h00);
    send_beat(tod_pkg::CMD_BUTTONS, 6'h15);
    send_beat(tod_pkg::CMD_TICK, 6'h2A);
    send_beat(tod_pkg::CMD_BUTTONS, 6'h00);

    // zero rate acts as one
    set_rate(16'd0);
    repeat (3) send_beat(tod_pkg::CMD_TICK, 6'h00);

    // largest rate, then lowered below the running count
    set_rate(16'hFFFF);
    repeat (4) send_beat(tod_pkg::CMD_TICK, 6'h00);
    set_rate(16'd2);
    repeat (2) send_beat(tod_pkg::CMD_TICK, 6'h00);

    for (int p = 0; p < 8; p++) begin
      set_rate(rate_plan[p]);
      steady = (p == 2);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          send_beat(tod_pkg::CMD_TICK, 6'($urandom_range(0, 63)));
          sent++;
        end else if (pick < 8) begin
          // press then release none, some or all of the pressed buttons
          press = 6'($urandom_range(0, 63));
          send_beat(tod_pkg::CMD_BUTTONS, press);
          send_beat(tod_pkg::CMD_BUTTONS, press & 6'($urandom_range(0, 63)));
          sent += 2;
        end else begin
          send_beat(tod_pkg::CMD_BUTTONS, 6'($urandom_range(0, 63)));
          sent++;
        end
      end
    end
    steady = 1'b0;

    settle();
    $display("%0d tick and button beats sent over %0d rate settings", beats, rate_writes + 1);
    $display("%0d results compared, %0d with display update, %0d mismatches",
             readings, updates, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tod_pkg.sv
src/time_of_day_clock.sv
tb/sv/time_of_day_check.sv
tb/sv/time_of_day_clock_test.sv
